// ===== rtl/core/wasm_instruction_encoder_core_defines.svh =====
// Assertion macros shared by the encoder core modules.
`ifndef WASM_INSTRUCTION_ENCODER_CORE_DEFINES_SVH
`define WASM_INSTRUCTION_ENCODER_CORE_DEFINES_SVH

// Clocked check, muted while reset is held.
`define WIC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds across reset.
`define WIC_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/wic_pkg.sv =====
// Types, constants and tables of the instruction encoder core.
`timescale 1ns / 1ps

package wic_pkg;

  // instruction kinds on mode_i
  localparam logic [3:0] MODE_CONST      = 4'd0;
  localparam logic [3:0] MODE_LOAD       = 4'd1;
  localparam logic [3:0] MODE_STORE      = 4'd2;
  localparam logic [3:0] MODE_GLOBAL_GET = 4'd3;
  localparam logic [3:0] MODE_GLOBAL_SET = 4'd4;
  localparam logic [3:0] MODE_LOCAL_GET  = 4'd5;
  localparam logic [3:0] MODE_LOCAL_SET  = 4'd6;
  localparam logic [3:0] MODE_LOCAL_TEE  = 4'd7;
  localparam logic [3:0] MODE_CALL       = 4'd8;
  localparam logic [3:0] MODE_CALL_IND   = 4'd9;

  localparam logic [7:0] ALIGN_BYTE  = 8'h02;
  localparam logic [7:0] TABLE_BYTE  = 8'h00;
  localparam logic [2:0] LEB_MAX_LEN = 3'd5;

  typedef logic [1:0] pc_t;
  localparam pc_t PC_OPC   = 2'd0;
  localparam pc_t PC_ALIGN = 2'd1;
  localparam pc_t PC_LEB   = 2'd2;
  localparam pc_t PC_TAIL  = 2'd3;

  typedef enum logic [1:0] {
    SRC_OPC,
    SRC_ALIGN,
    SRC_LEB,
    SRC_ZERO
  } src_e;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_NOT_MEM,
    COND_LEB_MORE
  } cond_e;

  typedef enum logic [1:0] {
    FIN_NEVER,
    FIN_ALWAYS,
    FIN_UNLESS_CI
  } fin_e;

  // one control word: byte source, jump condition and target, end rule
  typedef struct packed {
    src_e  src;
    cond_e cond;
    pc_t   target;
    fin_e  fin;
  } ucode_t;

  // sequencer to datapath
  typedef struct packed {
    logic load;
    logic emit;
    src_e src;
    logic last;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic out_free;
    logic leb_more;
  } stat_t;

  function automatic logic mode_valid(logic [3:0] mode);
    return mode <= MODE_CALL_IND;
  endfunction

  function automatic logic [7:0] opcode_of(logic [3:0] mode);
    logic [7:0] opc;
    case (mode)
      MODE_CONST:      opc = 8'h41;
      MODE_LOAD:       opc = 8'h28;
      MODE_STORE:      opc = 8'h36;
      MODE_GLOBAL_GET: opc = 8'h23;
      MODE_GLOBAL_SET: opc = 8'h24;
      MODE_LOCAL_GET:  opc = 8'h20;
      MODE_LOCAL_SET:  opc = 8'h21;
      MODE_LOCAL_TEE:  opc = 8'h22;
      MODE_CALL:       opc = 8'h10;
      MODE_CALL_IND:   opc = 8'h11;
      default:         opc = 8'h00;
    endcase
    return opc;
  endfunction

  // signed LEB length from the magnitude; the most negative value gives 2^31
  function automatic logic [2:0] leb_len(logic [31:0] v);
    logic [31:0] mag;
    logic [2:0]  len;
    mag = v[31] ? (~v + 32'd1) : v;
    if (mag[31:6] == '0) begin
      len = 3'd1;
    end else if (mag[31:12] == '0) begin
      len = 3'd2;
    end else if (mag[31:18] == '0) begin
      len = 3'd3;
    end else if (mag[31:24] == '0) begin
      len = 3'd4;
    end else begin
      len = LEB_MAX_LEN;
    end
    return len;
  endfunction

endpackage

// ===== rtl/core/wic_ucode_rom.sv =====
// Control store of the encoder sequencer.
`timescale 1ns / 1ps

module wic_ucode_rom (
  input  wic_pkg::pc_t   pc_i,
  output wic_pkg::ucode_t ucode_o
);

  always_comb begin
    case (pc_i)
      // opcode; skip the alignment step unless load or store
      wic_pkg::PC_OPC: begin
        ucode_o = '{src: wic_pkg::SRC_OPC, cond: wic_pkg::COND_NOT_MEM,
                    target: wic_pkg::PC_LEB, fin: wic_pkg::FIN_NEVER};
      end
      wic_pkg::PC_ALIGN: begin
        ucode_o = '{src: wic_pkg::SRC_ALIGN, cond: wic_pkg::COND_NONE,
                    target: wic_pkg::PC_OPC, fin: wic_pkg::FIN_NEVER};
      end
      // loop on itself while LEB bytes remain
      wic_pkg::PC_LEB: begin
        ucode_o = '{src: wic_pkg::SRC_LEB, cond: wic_pkg::COND_LEB_MORE,
                    target: wic_pkg::PC_LEB, fin: wic_pkg::FIN_UNLESS_CI};
      end
      default: begin
        ucode_o = '{src: wic_pkg::SRC_ZERO, cond: wic_pkg::COND_NONE,
                    target: wic_pkg::PC_OPC, fin: wic_pkg::FIN_ALWAYS};
      end
    endcase
  end

endmodule

// ===== rtl/core/wic_seq.sv =====
// Step counter and branch logic of the encoder sequencer.
`timescale 1ns / 1ps
`include "wasm_instruction_encoder_core_defines.svh"

module wic_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [3:0]     mode_i,
  input  wic_pkg::stat_t stat_i,
  output wic_pkg::ctrl_t ctrl_o
);

  logic            busy_q, busy_d;
  wic_pkg::pc_t    pc_q, pc_d;
  logic            is_mem_q, is_mem_d;
  logic            is_ci_q, is_ci_d;
  wic_pkg::ucode_t uw;
  logic            cond_hit, fin_hit, emit, load;

  wic_ucode_rom u_rom (
    .pc_i    (pc_q),
    .ucode_o (uw)
  );

  assign in_ready_o = !busy_q;
  assign load       = in_valid_i && !busy_q && wic_pkg::mode_valid(mode_i);
  assign emit       = busy_q && stat_i.out_free;

  always_comb begin
    case (uw.cond)
      wic_pkg::COND_NOT_MEM:  cond_hit = !is_mem_q;
      wic_pkg::COND_LEB_MORE: cond_hit = stat_i.leb_more;
      default:                cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    case (uw.fin)
      wic_pkg::FIN_ALWAYS:    fin_hit = 1'b1;
      wic_pkg::FIN_UNLESS_CI: fin_hit = !is_ci_q;
      default:                fin_hit = 1'b0;
    endcase
  end

  always_comb begin
    busy_d   = busy_q;
    pc_d     = pc_q;
    is_mem_d = is_mem_q;
    is_ci_d  = is_ci_q;
    if (load) begin
      busy_d   = 1'b1;
      pc_d     = wic_pkg::PC_OPC;
      is_mem_d = mode_i inside {wic_pkg::MODE_LOAD, wic_pkg::MODE_STORE};
      is_ci_d  = (mode_i == wic_pkg::MODE_CALL_IND);
    end else if (emit) begin
      if (cond_hit) begin
        pc_d = uw.target;
      end else if (fin_hit) begin
        busy_d = 1'b0;
      end else begin
        pc_d = wic_pkg::pc_t'(pc_q + 2'd1);
      end
    end
  end

  assign ctrl_o = '{load: load, emit: emit, src: uw.src, last: !cond_hit && fin_hit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      pc_q     <= wic_pkg::PC_OPC;
      is_mem_q <= 1'b0;
      is_ci_q  <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      pc_q     <= pc_d;
      is_mem_q <= is_mem_d;
      is_ci_q  <= is_ci_d;
    end
  end

  `WIC_ASSERT(a_load_starts_at_opc, load |=> busy_q && pc_q == wic_pkg::PC_OPC, "item did not start at opcode step")
  `WIC_ASSERT(a_align_only_mem, busy_q && pc_q == wic_pkg::PC_ALIGN |-> is_mem_q, "alignment step outside load or store")
  `WIC_ASSERT(a_tail_only_ci, busy_q && pc_q == wic_pkg::PC_TAIL |-> is_ci_q, "table step outside call_indirect")
  `WIC_ASSERT_ANY(a_idle_after_reset, !rst_ni |=> !busy_q, "sequencer busy after reset")

endmodule

// ===== rtl/core/wic_dp.sv =====
// Operand shifter, byte select and output register of the encoder.
`timescale 1ns / 1ps
`include "wasm_instruction_encoder_core_defines.svh"

module wic_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [3:0]     mode_i,
  input  logic [31:0]    operand_i,
  input  wic_pkg::ctrl_t ctrl_i,
  output wic_pkg::stat_t stat_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           last_o
);

  logic [31:0] sh_q, sh_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [7:0]  opc_q;
  logic        out_valid_q;
  logic [7:0]  byte_q;
  logic        last_q;
  logic        leb_more;
  logic [7:0]  byte_d;

  assign leb_more = (cnt_q > 3'd1);
  assign stat_o   = '{out_free: !out_valid_q || out_ready_i, leb_more: leb_more};

  always_comb begin
    case (ctrl_i.src)
      wic_pkg::SRC_OPC:   byte_d = opc_q;
      wic_pkg::SRC_ALIGN: byte_d = wic_pkg::ALIGN_BYTE;
      wic_pkg::SRC_LEB:   byte_d = {leb_more, sh_q[6:0]};
      default:            byte_d = wic_pkg::TABLE_BYTE;
    endcase
  end

  always_comb begin
    sh_d  = sh_q;
    cnt_d = cnt_q;
    if (ctrl_i.load) begin
      sh_d  = operand_i;
      cnt_d = wic_pkg::leb_len(operand_i);
    end else if (ctrl_i.emit && ctrl_i.src == wic_pkg::SRC_LEB) begin
      sh_d  = {{7{sh_q[31]}}, sh_q[31:7]};
      cnt_d = cnt_q - 3'd1;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    cnt_q <= cnt_d;
    if (ctrl_i.load) begin
      opc_q <= wic_pkg::opcode_of(mode_i);
    end
    if (ctrl_i.emit) begin
      byte_q <= byte_d;
      last_q <= ctrl_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = byte_q;
  assign last_o      = last_q;

  `WIC_ASSERT(a_leb_cnt_range, ctrl_i.emit && ctrl_i.src == wic_pkg::SRC_LEB |-> cnt_q != 3'd0 && cnt_q <= wic_pkg::LEB_MAX_LEN, "LEB byte count out of range")
  `WIC_ASSERT(a_leb_last_at_one, ctrl_i.emit && ctrl_i.src == wic_pkg::SRC_LEB && !leb_more |=> out_byte_o[7] == 1'b0, "final LEB byte has continuation bit")

endmodule

// ===== rtl/core/wasm_instruction_encoder_core.sv =====
// Top level of the WebAssembly instruction encoder core.
`timescale 1ns / 1ps

// Encodes one instruction request (mode_i, operand_i) into its WebAssembly
// byte stream: opcode, an alignment byte of 2 for load and store, the operand
// in signed LEB128 (1 to 5 bytes, length picked from the operand magnitude:
// below 2^6, 2^12, 2^18, 2^24, else five), and a table byte of 0 for
// call_indirect. last_o marks the final byte of each item. Mode codes above 9
// are taken and produce no bytes. A small microcoded sequencer steps through
// a four-word control store, one byte per step; the operand is held in a
// shifter that moves 7 bits per LEB byte. The sequencer takes an item of n
// bytes (2 to 7), then issues a single byte per step into the output
// register and holds while that register is still full; it takes no new
// item until the final byte is issued, and an unused mode is dropped when
// taken. The output register lets the next item be taken while the final
// byte of the previous one still waits. The block holds no state between
// items and needs no setup after reset.

module wasm_instruction_encoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  mode_i,
  input  logic [31:0] operand_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o
);

  wic_pkg::ctrl_t ctrl;
  wic_pkg::stat_t stat;

  // sequencer: step counter, branch conditions, control store
  wic_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // datapath: opcode latch, LEB shifter, byte mux, output register
  wic_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_i),
    .operand_i   (operand_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

endmodule
